// ===== rtl/ir_pulse_width_frame_decoder_assert.svh =====
// Assertion macros used by the checker of the infrared frame decoder.
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define IRFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("infrared frame decoder: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define IRFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("infrared frame decoder: next-cycle check failed");

`endif

// ===== rtl/irfd_pkg.sv =====
// Types, constants and a helper function of the infrared frame decoder.
package irfd_pkg;

  // Width of the phase length port and how many of its bits are used.
  localparam int unsigned PhaseBits     = 16;
  localparam int unsigned DURATION_BITS = 16;
  localparam int unsigned LenBits       = (DURATION_BITS < PhaseBits) ? DURATION_BITS : PhaseBits;

  // Configuration port.
  localparam int unsigned CfgBits    = 16;
  localparam int unsigned WinBits    = CfgBits + 1;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    RegHeaderLowCentre  = 3'd0,
    RegHeaderHighCentre = 3'd1,
    RegOneHighCentre    = 3'd2,
    RegZeroHighCentre   = 3'd3,
    RegGapLowCentre     = 3'd4,
    RegBitTolerance     = 3'd5,
    RegHeaderTolerance  = 3'd6
  } cfg_reg_e;

  localparam logic [CfgBits-1:0] HeaderLowReset  = 16'd576;
  localparam logic [CfgBits-1:0] HeaderHighReset = 16'd276;
  localparam logic [CfgBits-1:0] OneHighReset    = 16'd98;
  localparam logic [CfgBits-1:0] ZeroHighReset   = 16'd32;
  localparam logic [CfgBits-1:0] GapLowReset     = 16'd41;
  localparam logic [CfgBits-1:0] BitTolReset     = 16'd10;
  localparam logic [CfgBits-1:0] HeaderTolReset  = 16'd60;

  // Frame layout.
  localparam int unsigned ByteBits     = 8;
  localparam int unsigned StoreDepth   = 3;
  localparam int unsigned FrameBits    = 32;
  localparam int unsigned BitCountBits = 6;

  localparam logic [ByteBits-1:0] CodeOn  = 8'h46;
  localparam logic [ByteBits-1:0] CodeOff = 8'h15;

  typedef enum logic [1:0] {
    ClassOther = 2'd0,
    ClassOn    = 2'd1,
    ClassOff   = 2'd2
  } cmd_class_e;

  // Receiver state: waiting for a header, header low seen, inside a frame.
  typedef enum logic [1:0] {
    RxIdle  = 2'd0,
    RxArmed = 2'd1,
    RxData  = 2'd2
  } rx_state_e;

  // Depth of both decoupling queues.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  // Window hits of one phase, worked out by the front end.
  typedef struct packed {
    logic is_high;
    logic hdr_low;
    logic hdr_high;
    logic one;
    logic zero;
    logic gap;
  } phase_class_t;

  typedef struct packed {
    logic [ByteBits-1:0] first_byte;
    logic [ByteBits-1:0] second_byte;
    logic [ByteBits-1:0] third_byte;
    logic [ByteBits-1:0] fourth_byte;
    logic                check_ok;
    cmd_class_e          command_class;
  } frame_t;

  // Open window test: centre - tol < len < centre + tol, with no wrap-around.
  // The lower bound is rewritten as len + tol > centre so that it stays unsigned.
  function automatic logic in_window(input logic [LenBits-1:0] len,
                                     input logic [CfgBits-1:0] centre,
                                     input logic [CfgBits-1:0] tol);
    logic [WinBits-1:0] len_w;
    logic [WinBits-1:0] lo_sum;
    logic [WinBits-1:0] hi_sum;
    len_w  = WinBits'(len);
    lo_sum = len_w + WinBits'(tol);
    hi_sum = WinBits'(centre) + WinBits'(tol);
    return (lo_sum > WinBits'(centre)) && (len_w < hi_sum);
  endfunction

endpackage

// ===== rtl/irfd_cmd_fifo.sv =====
// Short queue of classified phases between the front end and the frame engine.
module irfd_cmd_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  irfd_pkg::phase_class_t wr_data_i,
  output logic                  full_o,
  input  logic                  rd_en_i,
  output irfd_pkg::phase_class_t rd_data_o,
  output logic                  valid_o
);
  import irfd_pkg::*;

  phase_class_t         mem_q [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0]  count_q, count_d;
  logic                 do_wr, do_rd;

  assign full_o    = (count_q == QCntBits'(QueueDepth));
  assign valid_o   = (count_q != '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/irfd_res_fifo.sv =====
// Output queue holding decoded frames until they are popped.
module irfd_res_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  irfd_pkg::frame_t wr_data_i,
  output logic            full_o,
  input  logic            rd_en_i,
  output irfd_pkg::frame_t rd_data_o,
  output logic            empty_o
);
  import irfd_pkg::*;

  frame_t               mem_q [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0]  count_q, count_d;
  logic                 do_wr, do_rd;

  assign full_o    = (count_q == QCntBits'(QueueDepth));
  assign empty_o   = (count_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == QPtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== rtl/irfd_classify.sv =====
// Front end: timing registers and window classification of each incoming phase.
module irfd_classify (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [irfd_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [irfd_pkg::CfgBits-1:0]         cfg_wdata_i,
  input  logic [irfd_pkg::PhaseBits-1:0]       phase_length_i,
  input  logic                                 phase_was_high_i,
  output irfd_pkg::phase_class_t               class_o
);
  import irfd_pkg::*;

  logic [CfgBits-1:0] hdr_low_c_q, hdr_high_c_q, one_c_q, zero_c_q, gap_c_q;
  logic [CfgBits-1:0] bit_tol_q, hdr_tol_q;
  logic [LenBits-1:0] len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_low_c_q  <= HeaderLowReset;
      hdr_high_c_q <= HeaderHighReset;
      one_c_q      <= OneHighReset;
      zero_c_q     <= ZeroHighReset;
      gap_c_q      <= GapLowReset;
      bit_tol_q    <= BitTolReset;
      hdr_tol_q    <= HeaderTolReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegHeaderLowCentre:  hdr_low_c_q  <= cfg_wdata_i;
        RegHeaderHighCentre: hdr_high_c_q <= cfg_wdata_i;
        RegOneHighCentre:    one_c_q      <= cfg_wdata_i;
        RegZeroHighCentre:   zero_c_q     <= cfg_wdata_i;
        RegGapLowCentre:     gap_c_q      <= cfg_wdata_i;
        RegBitTolerance:     bit_tol_q    <= cfg_wdata_i;
        RegHeaderTolerance:  hdr_tol_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Only the low duration bits of the measurement take part.
  assign len = phase_length_i[LenBits-1:0];

  always_comb begin
    class_o.is_high  = phase_was_high_i;
    class_o.hdr_low  = in_window(len, hdr_low_c_q, hdr_tol_q);
    class_o.hdr_high = in_window(len, hdr_high_c_q, hdr_tol_q);
    class_o.one      = in_window(len, one_c_q, bit_tol_q);
    class_o.zero     = in_window(len, zero_c_q, bit_tol_q);
    class_o.gap      = in_window(len, gap_c_q, bit_tol_q);
  end

endmodule

// ===== rtl/irfd_frame_engine.sv =====
// Back end: receiver state machine, bit assembly and frame check.
module irfd_frame_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  irfd_pkg::phase_class_t cmd_i,
  output logic                   cmd_pop_o,
  input  logic                   res_full_i,
  output logic                   res_valid_o,
  output irfd_pkg::frame_t       res_o
);
  import irfd_pkg::*;

  rx_state_e               state_q, state_d;
  logic [BitCountBits-1:0] cnt_q, cnt_d, next_cnt;
  logic [ByteBits-1:0]     shift_q, shift_d, base_shift, new_shift;
  logic [ByteBits-1:0]     bytes_q [StoreDepth];
  logic [ByteBits-1:0]     bytes_d [StoreDepth];
  logic                    go;
  logic                    check;

  // One classified phase is consumed per cycle unless the output queue is full.
  assign go        = cmd_valid_i && !res_full_i;
  assign cmd_pop_o = go;

  // The first bit of a frame starts from a cleared shift register.
  assign base_shift = (cnt_q == '0) ? '0 : shift_q;
  assign new_shift  = base_shift | {cmd_i.one, {(ByteBits - 1){1'b0}}};
  assign next_cnt   = cnt_q + 1'b1;
  assign check      = (bytes_q[2] == ~new_shift);

  always_comb begin
    res_o.first_byte  = bytes_q[0];
    res_o.second_byte = bytes_q[1];
    res_o.third_byte  = bytes_q[2];
    res_o.fourth_byte = new_shift;
    res_o.check_ok    = check;
    if (check && bytes_q[2] == CodeOn) begin
      res_o.command_class = ClassOn;
    end else if (check && bytes_q[2] == CodeOff) begin
      res_o.command_class = ClassOff;
    end else begin
      res_o.command_class = ClassOther;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    bytes_d     = bytes_q;
    res_valid_o = 1'b0;
    if (go) begin
      if (cmd_i.is_high) begin
        if (state_q == RxArmed && cmd_i.hdr_high) begin
          state_d = RxData;
          cnt_d   = '0;
        end else if (state_q == RxData) begin
          // A high phase that fits neither bit window is ignored.
          if (cmd_i.one || cmd_i.zero) begin
            if (cnt_q == '0) begin
              bytes_d = '{default: '0};
            end
            cnt_d   = next_cnt;
            shift_d = new_shift >> 1;
            if (next_cnt == BitCountBits'(ByteBits)) begin
              bytes_d[0] = new_shift;
            end
            if (next_cnt == BitCountBits'(2 * ByteBits)) begin
              bytes_d[1] = new_shift;
            end
            if (next_cnt == BitCountBits'(3 * ByteBits)) begin
              bytes_d[2] = new_shift;
            end
            if (next_cnt == BitCountBits'(FrameBits)) begin
              res_valid_o = 1'b1;
              state_d     = RxIdle;
              cnt_d       = '0;
            end
          end
        end else begin
          state_d = RxIdle;
          cnt_d   = '0;
        end
      end else begin
        if (cmd_i.hdr_low) begin
          state_d = RxArmed;
          cnt_d   = '0;
        end else if (state_q == RxData && !cmd_i.gap) begin
          state_d = RxIdle;
          cnt_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RxIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    bytes_q <= bytes_d;
  end

endmodule

// ===== rtl/ir_pulse_width_frame_decoder.sv =====
// Top level of the infrared pulse width frame decoder.
// Each item is the measured length of one receiver phase and whether it was high.
// A low phase inside the header low window arms the receiver, and a high phase
// inside the header high window then opens a frame; data bits are high phases in
// the one or zero window (one wins where both match), and a low phase outside the
// gap window drops the frame. After 32 bits, collected least significant bit
// first, one result item carries the four bytes, the check that the third byte is
// the inverse of the fourth, and the command class (on for 0x46, off for 0x15).
// Windows are open intervals around each centre register. The block takes one
// item per clock cycle while full is low: the front end classifies the phase
// against all windows in the cycle it is accepted, and the frame engine consumes
// one classified phase per cycle from a two-entry queue unless the result queue
// is full. A completing item passes the phase queue and then the result queue
// before its frame appears on the result ports. The two queues let the input side
// keep pushing while a finished frame waits to be popped; full only rises once
// the result queue is full and the phase queue has filled behind it. Timing
// registers are written through the cfg port and should only be changed while
// the block is idle.
module ir_pulse_width_frame_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [irfd_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [irfd_pkg::CfgBits-1:0]    cfg_wdata_i,
  // Phase input, queue style
  input  logic                            push,
  output logic                            full,
  input  logic [irfd_pkg::PhaseBits-1:0]  phase_length_i,
  input  logic                            phase_was_high_i,
  // Frame output, queue style
  output logic                            empty,
  input  logic                            pop,
  output logic [irfd_pkg::ByteBits-1:0]   first_byte_o,
  output logic [irfd_pkg::ByteBits-1:0]   second_byte_o,
  output logic [irfd_pkg::ByteBits-1:0]   third_byte_o,
  output logic [irfd_pkg::ByteBits-1:0]   fourth_byte_o,
  output logic                            check_ok_o,
  output logic [1:0]                      command_class_o
);
  import irfd_pkg::*;

  phase_class_t in_class;
  phase_class_t cmd;
  logic         cmd_valid;
  logic         cmd_pop;
  logic         res_valid;
  logic         res_full;
  frame_t       res_in;
  frame_t       res_out;

  // Front end: the timing registers and the window comparators.
  irfd_classify u_classify (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .phase_length_i   (phase_length_i),
    .phase_was_high_i (phase_was_high_i),
    .class_o          (in_class)
  );

  // The queue's own full flag is the input side's back-pressure.
  irfd_cmd_fifo u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (push),
    .wr_data_i (in_class),
    .full_o    (full),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd),
    .valid_o   (cmd_valid)
  );

  // Back end: receiver state and bit assembly.
  irfd_frame_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_valid_o (res_valid),
    .res_o       (res_in)
  );

  irfd_res_fifo u_res_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res_in),
    .full_o    (res_full),
    .rd_en_i   (pop),
    .rd_data_o (res_out),
    .empty_o   (empty)
  );

  assign first_byte_o    = res_out.first_byte;
  assign second_byte_o   = res_out.second_byte;
  assign third_byte_o    = res_out.third_byte;
  assign fourth_byte_o   = res_out.fourth_byte;
  assign check_ok_o      = res_out.check_ok;
  assign command_class_o = res_out.command_class;

endmodule

// ===== rtl/irfd_checker.sv =====
// Port-level assertions of the infrared frame decoder, bound to the top level.
`include "ir_pulse_width_frame_decoder_assert.svh"

module irfd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [irfd_pkg::CfgIdxBits-1:0] cfg_index_i,
  input logic [irfd_pkg::CfgBits-1:0]    cfg_wdata_i,
  input logic                            push,
  input logic                            full,
  input logic [irfd_pkg::PhaseBits-1:0]  phase_length_i,
  input logic                            phase_was_high_i,
  input logic                            empty,
  input logic                            pop,
  input logic [irfd_pkg::ByteBits-1:0]   first_byte_o,
  input logic [irfd_pkg::ByteBits-1:0]   second_byte_o,
  input logic [irfd_pkg::ByteBits-1:0]   third_byte_o,
  input logic [irfd_pkg::ByteBits-1:0]   fourth_byte_o,
  input logic                            check_ok_o,
  input logic [1:0]                      command_class_o
);
  import irfd_pkg::*;

  logic                      class_ok;
  logic [4*ByteBits+2:0]     result_bus;

  assign class_ok = check_ok_o &&
                    ((command_class_o == ClassOn && third_byte_o == CodeOn) ||
                     (command_class_o == ClassOff && third_byte_o == CodeOff));
  assign result_bus = {first_byte_o, second_byte_o, third_byte_o, fourth_byte_o,
                       check_ok_o, command_class_o};

  // The check flag must agree with the two command bytes it covers.
  `IRFD_ASSERT_NOW(a_check_matches, !empty, check_ok_o == (third_byte_o == ~fourth_byte_o))

  // A command class other than "other" needs a passing check and the right code.
  `IRFD_ASSERT_NOW(a_class_valid, !empty && command_class_o != ClassOther, class_ok)

  // The input only pushes back while a frame is waiting at the output.
  `IRFD_ASSERT_NOW(a_full_needs_frame, full, !empty)

  // A waiting frame stays put until it is popped.
  `IRFD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result_bus))

endmodule

bind ir_pulse_width_frame_decoder irfd_checker u_irfd_checker (.*);
